>>> rtl/vmrf_pkg.sv
// shared types and constants of the virtio mmio register file
package vmrf_pkg;

	localparam int QUEUE_COUNT = 2;
	localparam logic [31:0] QUEUE_MAX = 32'd4096;

	localparam int QIDX_W = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
	localparam int QSIZE_W = $clog2(int'(QUEUE_MAX) + 1);

	localparam logic [31:0] MAGIC_WORD = 32'h7472_6976;
	localparam logic [31:0] VERSION = 32'd1;
	localparam logic [31:0] INT_STATUS = 32'd1;
	localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
	localparam logic [31:0] RESET_PG_LEN = 32'h0000_1000;
	localparam logic [31:0] RESET_DEVICE_ID = 32'd1;
	localparam logic [31:0] RESET_VENDOR_ID = 32'h0000_0044;

	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 40;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VENDOR_ID = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFERED_FEATURES = 2'd2;

	// word index (offset bits 7:2) of each register below the device window
	localparam logic [5:0] REG_MAGIC = 6'd0;
	localparam logic [5:0] REG_VERSION = 6'd1;
	localparam logic [5:0] REG_DEVICE_ID = 6'd2;
	localparam logic [5:0] REG_VENDOR_ID = 6'd3;
	localparam logic [5:0] REG_HOST_FEATURES = 6'd4;
	localparam logic [5:0] REG_GUEST_FEATURES = 6'd8;
	localparam logic [5:0] REG_GUEST_PG_LEN = 6'd10;
	localparam logic [5:0] REG_QUEUE_SEL = 6'd12;
	localparam logic [5:0] REG_QUEUE_NUM_MAX = 6'd13;
	localparam logic [5:0] REG_QUEUE_NUM = 6'd14;
	localparam logic [5:0] REG_QUEUE_ALIGN = 6'd15;
	localparam logic [5:0] REG_QUEUE_PFN = 6'd16;
	localparam logic [5:0] REG_INT_STATUS = 6'd24;
	localparam logic [5:0] REG_STATUS = 6'd28;

	localparam logic ACT_READ = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	typedef struct packed {
		logic        action;
		logic [11:0] reg_offset;
		logic [31:0] write_value;
	} vmrf_req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        device_reset;
	} vmrf_rsp_t;

	typedef struct packed {
		logic                 we;
		logic [CFG_IDX_W-1:0] index;
		logic [31:0]          data;
	} vmrf_cfg_wr_t;

endpackage

>>> rtl/vmrf_core.sv
// register state, read decode and write update of the register file
module vmrf_core import vmrf_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  vmrf_cfg_wr_t cfg_wr,
	input  logic         exec,
	input  vmrf_req_t    req,
	output vmrf_rsp_t    rsp
);

	logic [31:0]        device_id_q;
	logic [31:0]        vendor_id_q;
	logic [31:0]        offered_features_q;
	logic [31:0]        accepted_features_q;
	logic [31:0]        guest_pg_len_q;
	logic               queue_chosen_q;
	logic [QIDX_W-1:0]  queue_index_q;
	logic [QSIZE_W-1:0] queue_size_q [QUEUE_COUNT];
	logic [31:0]        queue_alignment_q [QUEUE_COUNT];
	logic [31:0]        queue_frame_q [QUEUE_COUNT];
	logic [31:0]        device_status_q;

	logic [5:0]         word;
	logic               in_window;
	logic               do_write;
	logic [31:0]        rd_value;
	logic [QSIZE_W-1:0] size_clamped;

	assign word = req.reg_offset[7:2];
	assign in_window = (req.reg_offset[11:8] == 4'd0);
	assign do_write = exec && (req.action == ACT_WRITE) && in_window;
	assign size_clamped = (req.write_value > QUEUE_MAX) ? QUEUE_MAX[QSIZE_W-1:0]
		: req.write_value[QSIZE_W-1:0];

	always_comb begin
		unique case (word)
			REG_MAGIC:         rd_value = MAGIC_WORD;
			REG_VERSION:       rd_value = VERSION;
			REG_DEVICE_ID:     rd_value = device_id_q;
			REG_VENDOR_ID:     rd_value = vendor_id_q;
			REG_HOST_FEATURES: rd_value = offered_features_q;
			REG_QUEUE_NUM_MAX: rd_value = queue_chosen_q ? QUEUE_MAX : 32'd0;
			REG_QUEUE_PFN:     rd_value = queue_chosen_q ? queue_frame_q[queue_index_q] : 32'd0;
			REG_INT_STATUS:    rd_value = INT_STATUS;
			REG_STATUS:        rd_value = device_status_q;
			default:           rd_value = ALL_ONES;
		endcase
	end

	always_comb begin
		rsp = '0;
		if (req.action == ACT_READ) begin
			rsp.read_data = in_window ? rd_value : 32'd0;
		end else begin
			rsp.device_reset = in_window && (word == REG_STATUS) && (req.write_value == 32'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_id_q <= RESET_DEVICE_ID;
			vendor_id_q <= RESET_VENDOR_ID;
			offered_features_q <= 32'd0;
		end else if (cfg_wr.we) begin
			unique case (cfg_wr.index)
				CFG_DEVICE_ID:        device_id_q <= cfg_wr.data;
				CFG_VENDOR_ID:        vendor_id_q <= cfg_wr.data;
				CFG_OFFERED_FEATURES: offered_features_q <= cfg_wr.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accepted_features_q <= 32'd0;
			guest_pg_len_q <= RESET_PG_LEN;
			queue_chosen_q <= 1'b0;
			queue_index_q <= '0;
			device_status_q <= 32'd0;
			for (int q = 0; q < QUEUE_COUNT; q++) begin
				queue_size_q[q] <= '0;
				queue_alignment_q[q] <= 32'd0;
				queue_frame_q[q] <= 32'd0;
			end
		end else if (do_write) begin
			unique case (word)
				REG_GUEST_FEATURES: accepted_features_q <= req.write_value;
				REG_GUEST_PG_LEN:   guest_pg_len_q <= req.write_value;
				REG_QUEUE_SEL: begin
					// out of range deselects but keeps the old index
					if (req.write_value < 32'(QUEUE_COUNT)) begin
						queue_chosen_q <= 1'b1;
						queue_index_q <= req.write_value[QIDX_W-1:0];
					end else begin
						queue_chosen_q <= 1'b0;
					end
				end
				REG_QUEUE_NUM: begin
					if (queue_chosen_q) queue_size_q[queue_index_q] <= size_clamped;
				end
				REG_QUEUE_ALIGN: begin
					if (queue_chosen_q) queue_alignment_q[queue_index_q] <= req.write_value;
				end
				REG_QUEUE_PFN: begin
					if (queue_chosen_q) queue_frame_q[queue_index_q] <= req.write_value;
				end
				REG_STATUS: begin
					device_status_q <= req.write_value;
					// status zero is a device reset: frames go, sizes stay
					if (req.write_value == 32'd0) begin
						for (int q = 0; q < QUEUE_COUNT; q++) queue_frame_q[q] <= 32'd0;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

>>> rtl/virtio_mmio_register_file_unit.sv
// top level of the virtio mmio register file: request and result registers
//
// Legacy virtio-mmio register file with two virtqueues.
// Requests enter on the s_axis channel: tuser is the access kind (0 read,
// 1 write), tdata carries the byte offset and the write data. Each request
// gives one result on the m_axis channel: read data (zero on a write) and a
// device reset flag that is set when a write puts zero into the status.
// Device id, vendor id and host features are set on the cfg channel, which
// is always ready; write it only while no request is in flight.
// A request is registered at acceptance, then decoded and applied to the state
// as it moves on into the result register, where its result waits until the
// receiver takes it.
// One request per cycle is sustained while the receiver takes results: the
// decode is a single pass of logic between the request and result registers.
// When the receiver stalls, the result register holds its item and the
// request register holds one more; tready falls only when both are full.
// Reset (arst_n low) empties both registers and loads every register of the
// file with its reset value at once; no clearing pass is needed.
module virtio_mmio_register_file_unit import vmrf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,  // reg_offset[11:0], write_value[43:12], zero pad
	input  logic                 s_axis_tuser,  // action
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata,  // read_data[31:0], device_reset[32], zero pad
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	vmrf_req_t    req_s1;
	logic         valid_s1;
	vmrf_rsp_t    rsp_s2;
	logic         valid_s2;
	vmrf_rsp_t    rsp;
	vmrf_cfg_wr_t cfg_wr;
	logic         s_accept;
	logic         advance;

	assign cfg_ready = 1'b1;
	assign cfg_wr.we = cfg_valid;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data = cfg_data;

	assign advance = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign s_accept = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= s_accept || (valid_s1 && !advance);
			valid_s2 <= advance || (valid_s2 && !m_axis_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			req_s1.action <= s_axis_tuser;
			req_s1.reg_offset <= s_axis_tdata[11:0];
			req_s1.write_value <= s_axis_tdata[43:12];
		end
		if (advance) rsp_s2 <= rsp;
	end

	vmrf_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_wr (cfg_wr),
		.exec   (advance),
		.req    (req_s1),
		.rsp    (rsp)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata = {{(M_TDATA_W - 33){1'b0}}, rsp_s2.device_reset, rsp_s2.read_data};

	// a request that moves on always lands in the result register
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("executed request did not reach the result register");

	// a stalled result holds the request register in place
	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !m_axis_tready |=> valid_s1 && $stable(req_s1))
		else $error("request lost while the result was stalled");

	// a device reset comes only from a write, so its read data is zero
	a_reset_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rsp_s2.device_reset |-> rsp_s2.read_data == 32'd0)
		else $error("device reset result carries read data");

	// room for a request whenever the request register is empty
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
		else $error("request refused with an empty request register");

endmodule
